FILE: hw/rtl/npq_pkg.sv
package npq_pkg;

  localparam int unsigned CMD_W  = 1;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned HID_W  = 8;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned QCNT_W = 5;
  localparam int unsigned NEST_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_RAISE    = 1'b0,
    CMD_COMPLETE = 1'b1
  } npq_cmd_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_START     = 3'd0,
    ACT_RESUME    = 3'd1,
    ACT_IDLE      = 3'd2,
    ACT_NONE      = 3'd3,
    ACT_IDLE_DONE = 3'd4
  } npq_action_e;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [HID_W-1:0]  handler;
  } npq_entry_t;

  // per-transfer control broadcast to every queue cell
  typedef struct packed {
    logic en;   // transfer accepted this cycle
    logic ins;  // new task goes into the queue
    logic pop;  // head leaves the queue
  } npq_cell_ctrl_t;

endpackage

FILE: hw/rtl/npq_in_if.sv
interface npq_in_if;
  logic                        valid;
  logic                        ready;
  logic [npq_pkg::CMD_W-1:0]   command;
  logic [npq_pkg::PRIO_W-1:0]  priority_req;
  logic [npq_pkg::HID_W-1:0]   handler_id;

  modport source (output valid, command, priority_req, handler_id, input ready);
  modport sink   (input valid, command, priority_req, handler_id, output ready);
endinterface

FILE: hw/rtl/npq_out_if.sv
interface npq_out_if;
  logic                        valid;
  logic                        ready;
  logic [npq_pkg::ACT_W-1:0]   action;
  logic [npq_pkg::HID_W-1:0]   started_handler;
  logic [npq_pkg::PRIO_W-1:0]  running_priority;
  logic [npq_pkg::QCNT_W-1:0]  queued_count;
  logic                        dropped;
  logic [npq_pkg::NEST_W-1:0]  nest_level;

  modport source (output valid, action, started_handler, running_priority, queued_count,
                  dropped, nest_level, input ready);
  modport sink   (input valid, action, started_handler, running_priority, queued_count,
                  dropped, nest_level, output ready);
endinterface

FILE: hw/rtl/nested_priority_task_queue_core.sv
// Channel  Dir  Payload                                                   Transfer
// in_i     in   command, priority_req, handler_id                         valid & ready
// out_o    out  action, started_handler, running_priority, queued_count,  valid & ready
//               dropped, nest_level
//
// One item per cycle unless out_o stalls; results come in the cycle after their input.
// The queue is a row of cells that insert and shift the head out in the same cycle.
// Reset clears length, running priority, nesting depth and the output valid.
// in_i.ready drops only while a result is held and out_o.ready is low.
module nested_priority_task_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned NEST_DEPTH  = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  npq_in_if.sink          in_i,
  npq_out_if.source       out_o
);

  localparam int unsigned LEN_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SD_W   = $clog2(NEST_DEPTH + 1);
  localparam int unsigned SIDX_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  logic [LEN_W-1:0]                 len_q, len_d, len_ins;
  logic [npq_pkg::PRIO_W-1:0]       cur_q, cur_d;
  logic [SD_W-1:0]                  sd_q, sd_d;
  logic [npq_pkg::PRIO_W-1:0]       saved_q [NEST_DEPTH];

  logic                             out_valid_q;
  npq_pkg::npq_action_e             act_q, act_d;
  logic [npq_pkg::HID_W-1:0]        started_q, started_d;
  logic [npq_pkg::PRIO_W-1:0]       run_q;
  logic [npq_pkg::QCNT_W-1:0]       qcnt_q;
  logic                             drop_q, drop_d;
  logic [npq_pkg::NEST_W-1:0]       nest_q;

  logic                             fire, raise, full, push;
  logic [npq_pkg::PRIO_W-1:0]       prio_sat;
  npq_pkg::npq_cell_ctrl_t          ctrl;
  logic [SIDX_W-1:0]                push_idx, pop_idx;

  npq_pkg::npq_entry_t              q_w [QUEUE_DEPTH];
  npq_pkg::npq_entry_t              a_w [QUEUE_DEPTH];
  logic                             ge_w [QUEUE_DEPTH];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;
  assign raise      = npq_pkg::npq_cmd_e'(in_i.command) == npq_pkg::CMD_RAISE;
  assign prio_sat   = (in_i.priority_req == '0) ? npq_pkg::PRIO_W'(1) : in_i.priority_req;
  assign full       = len_q == LEN_W'(QUEUE_DEPTH);
  assign len_ins    = len_q + LEN_W'(raise && !full);
  assign push_idx   = sd_q[SIDX_W-1:0];
  assign pop_idx    = SIDX_W'(sd_q - SD_W'(1));

  always_comb begin
    ctrl.en   = fire;
    ctrl.ins  = raise && !full;
    ctrl.pop  = 1'b0;
    push      = 1'b0;
    act_d     = npq_pkg::ACT_NONE;
    started_d = '0;
    drop_d    = raise && full;
    cur_d     = cur_q;
    sd_d      = sd_q;
    if (raise) begin
      if (len_ins != '0) begin
        if (cur_q == '0) begin
          ctrl.pop = 1'b1;
        end else if (prio_sat > cur_q && sd_q < SD_W'(NEST_DEPTH)) begin
          ctrl.pop = 1'b1;
          push     = 1'b1;
          sd_d     = sd_q + SD_W'(1);
        end
      end
    end else begin
      if (cur_q == '0) begin
        act_d = npq_pkg::ACT_IDLE_DONE;
      end else if (sd_q != '0) begin
        sd_d   = sd_q - SD_W'(1);
        cur_d  = saved_q[pop_idx];
        act_d  = npq_pkg::ACT_RESUME;
      end else if (len_q != '0) begin
        ctrl.pop = 1'b1;
      end else begin
        cur_d = '0;
        act_d = npq_pkg::ACT_IDLE;
      end
    end
    if (ctrl.pop) begin
      cur_d     = a_w[0].prio;
      started_d = a_w[0].handler;
      act_d     = npq_pkg::ACT_START;
    end
    len_d = len_ins - LEN_W'(ctrl.pop);
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    npq_pkg::npq_entry_t left_q, right_a;
    logic                left_ge;
    if (i == 0) begin : g_head
      assign left_q  = '0;
      assign left_ge = 1'b1;
    end else begin : g_body
      assign left_q  = q_w[i-1];
      assign left_ge = ge_w[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_a = a_w[i];
    end else begin : g_mid
      assign right_a = a_w[i+1];
    end
    npq_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX         (i)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .len_i         (len_q),
      .new_prio_i    (prio_sat),
      .new_handler_i (in_i.handler_id),
      .left_q_i      (left_q),
      .left_ge_i     (left_ge),
      .right_a_i     (right_a),
      .q_o           (q_w[i]),
      .ge_o          (ge_w[i]),
      .a_o           (a_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      cur_q       <= '0;
      sd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        len_q <= len_d;
        cur_q <= cur_d;
        sd_q  <= sd_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && push) begin
      saved_q[push_idx] <= cur_q;
    end
    if (fire) begin
      act_q     <= act_d;
      started_q <= started_d;
      run_q     <= cur_d;
      qcnt_q    <= npq_pkg::QCNT_W'(len_d);
      drop_q    <= drop_d;
      nest_q    <= npq_pkg::NEST_W'(sd_d);
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.action           = act_q;
  assign out_o.started_handler  = started_q;
  assign out_o.running_priority = run_q;
  assign out_o.queued_count     = qcnt_q;
  assign out_o.dropped          = drop_q;
  assign out_o.nest_level       = nest_q;

endmodule

FILE: hw/rtl/npq_cell.sv
module npq_cell #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned IDX         = 0,
  localparam int unsigned LEN_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  npq_pkg::npq_cell_ctrl_t       ctrl_i,
  input  logic [LEN_W-1:0]              len_i,
  input  logic [npq_pkg::PRIO_W-1:0]    new_prio_i,
  input  logic [npq_pkg::HID_W-1:0]     new_handler_i,
  input  npq_pkg::npq_entry_t           left_q_i,
  input  logic                          left_ge_i,
  input  npq_pkg::npq_entry_t           right_a_i,
  output npq_pkg::npq_entry_t           q_o,
  output logic                          ge_o,
  output npq_pkg::npq_entry_t           a_o
);

  npq_pkg::npq_entry_t entry_q, entry_d;
  npq_pkg::npq_entry_t new_entry;
  logic                valid;

  assign valid             = len_i > LEN_W'(IDX);
  assign ge_o              = valid && (entry_q.prio >= new_prio_i);
  assign new_entry.prio    = new_prio_i;
  assign new_entry.handler = new_handler_i;

  // entry after insertion: stay, take the new task, or take the left neighbor
  always_comb begin
    a_o = entry_q;
    if (ctrl_i.ins && !ge_o) begin
      a_o = left_ge_i ? new_entry : left_q_i;
    end
    entry_d = ctrl_i.pop ? right_a_i : a_o;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      entry_q <= entry_d;
    end
  end

  assign q_o = entry_q;

endmodule

FILE: dv/npq_dispatch_checker.sv
module npq_dispatch_checker #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned NEST_DEPTH  = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  npq_in_if    in_mon,
  npq_out_if   out_mon,
  output int   fail_cnt_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    npq_pkg::npq_action_e       action;
    logic [npq_pkg::HID_W-1:0]  started;
    logic [npq_pkg::PRIO_W-1:0] running;
    logic [npq_pkg::QCNT_W-1:0] queued;
    logic                       dropped;
    logic [npq_pkg::NEST_W-1:0] nest;
  } dispatch_t;

  npq_pkg::npq_entry_t        task_q[QUEUE_DEPTH];
  int unsigned                task_len;
  logic [npq_pkg::PRIO_W-1:0] run_prio;
  logic [npq_pkg::PRIO_W-1:0] saved_prio[NEST_DEPTH];
  int unsigned                saved_cnt;
  dispatch_t                  exp_dispatch_q[$];
  int                         fail_count = 0;

  function automatic logic [npq_pkg::HID_W-1:0] pop_head();
    logic [npq_pkg::HID_W-1:0] hid;
    hid      = task_q[0].handler;
    run_prio = task_q[0].prio;
    for (int i = 1; i < task_len; i++) task_q[i-1] = task_q[i];
    task_len--;
    return hid;
  endfunction

  task automatic predict_dispatch(input npq_pkg::npq_cmd_e cmd,
                                  input logic [npq_pkg::PRIO_W-1:0] prio_in,
                                  input logic [npq_pkg::HID_W-1:0] hid,
                                  output dispatch_t res);
    logic [npq_pkg::PRIO_W-1:0] prio;
    int unsigned                pos;
    res.action  = npq_pkg::ACT_NONE;
    res.started = '0;
    res.dropped = 1'b0;
    if (cmd == npq_pkg::CMD_RAISE) begin
      prio = (prio_in == '0) ? npq_pkg::PRIO_W'(1) : prio_in;
      if (task_len >= QUEUE_DEPTH) begin
        res.dropped = 1'b1;
      end else begin
        pos = 0;
        while (pos < task_len && task_q[pos].prio >= prio) pos++;
        for (int i = task_len; i > pos; i--) task_q[i] = task_q[i-1];
        task_q[pos].prio    = prio;
        task_q[pos].handler = hid;
        task_len++;
      end
      if (task_len > 0) begin
        if (run_prio == '0) begin
          res.started = pop_head();
          res.action  = npq_pkg::ACT_START;
        end else if (prio > run_prio && saved_cnt < NEST_DEPTH) begin
          saved_prio[saved_cnt] = run_prio;
          saved_cnt++;
          res.started = pop_head();
          res.action  = npq_pkg::ACT_START;
        end
      end
    end else begin
      if (run_prio == '0) begin
        res.action = npq_pkg::ACT_IDLE_DONE;
      end else if (saved_cnt > 0) begin
        saved_cnt--;
        run_prio   = saved_prio[saved_cnt];
        res.action = npq_pkg::ACT_RESUME;
      end else if (task_len > 0) begin
        res.started = pop_head();
        res.action  = npq_pkg::ACT_START;
      end else begin
        run_prio   = '0;
        res.action = npq_pkg::ACT_IDLE;
      end
    end
    res.running = run_prio;
    res.queued  = npq_pkg::QCNT_W'(task_len);
    res.nest    = npq_pkg::NEST_W'(saved_cnt);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dispatch_t exp_r;
    dispatch_t new_r;
    if (!rst_ni) begin
      task_len  = 0;
      run_prio  = '0;
      saved_cnt = 0;
      exp_dispatch_q.delete();
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (exp_dispatch_q.size() == 0) begin
          $error("result transfer with no result pending");
          fail_count++;
        end else begin
          exp_r = exp_dispatch_q.pop_front();
          check_field("action",           exp_r.action,  out_mon.action);
          check_field("started_handler",  exp_r.started, out_mon.started_handler);
          check_field("running_priority", exp_r.running, out_mon.running_priority);
          check_field("queued_count",     exp_r.queued,  out_mon.queued_count);
          check_field("dropped",          exp_r.dropped, out_mon.dropped);
          check_field("nest_level",       exp_r.nest,    out_mon.nest_level);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_dispatch(npq_pkg::npq_cmd_e'(in_mon.command), in_mon.priority_req,
                         in_mon.handler_id, new_r);
        exp_dispatch_q.push_back(new_r);
      end
      pending_o  <= exp_dispatch_q.size();
      fail_cnt_o <= fail_count;
    end
  end

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned NEST_DEPTH  = 4;
  localparam int unsigned N_RANDOM    = 800;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned LONG_HOLD   = 120;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int unsigned quiet_cycles = 0;

  npq_in_if  in_bus ();
  npq_out_if out_bus ();

  nested_priority_task_queue_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .NEST_DEPTH (NEST_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  npq_dispatch_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .NEST_DEPTH (NEST_DEPTH)
  ) i_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_bus),
    .out_mon   (out_bus),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_event(input npq_pkg::npq_cmd_e cmd,
                            input logic [npq_pkg::PRIO_W-1:0] prio,
                            input logic [npq_pkg::HID_W-1:0] hid);
    int unsigned gap;
    in_bus.valid        <= 1'b1;
    in_bus.command      <= cmd;
    in_bus.priority_req <= prio;
    in_bus.handler_id   <= hid;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // receiver: random ready pattern plus one long hold-off
  initial begin
    int unsigned rx_cycles;
    int unsigned run_len;
    int unsigned gap;
    bit          held;
    rx_cycles     = 0;
    held          = 1'b0;
    out_bus.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && rx_cycles >= 400) begin
        held = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_cycles += LONG_HOLD;
      end else begin
        run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        out_bus.ready <= 1'b1;
        repeat (run_len) @(posedge clk_i);
        gap = pick_gap();
        if (gap > 0) begin
          out_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        rx_cycles += run_len + gap;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned                sent;
    int unsigned                phase_len;
    int unsigned                raise_pct;
    int unsigned                sel;
    npq_pkg::npq_cmd_e          cmd;
    logic [npq_pkg::PRIO_W-1:0] prio;

    rst_ni              = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.command      = npq_pkg::CMD_RAISE;
    in_bus.priority_req = '0;
    in_bus.handler_id   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // idle completion, zero priority, preemption, equal priority
    send_event(npq_pkg::CMD_COMPLETE, 8'd0,   8'h00);
    send_event(npq_pkg::CMD_RAISE,    8'd0,   8'h00);
    send_event(npq_pkg::CMD_RAISE,    8'd255, 8'hFF);
    send_event(npq_pkg::CMD_RAISE,    8'd255, 8'hAA);
    send_event(npq_pkg::CMD_COMPLETE, 8'd0,   8'h00);
    send_event(npq_pkg::CMD_COMPLETE, 8'd0,   8'h00);
    send_event(npq_pkg::CMD_COMPLETE, 8'd0,   8'h00);
    // nesting stack full, FIFO among equal priorities, resume order
    for (int i = 1; i <= 6; i++) begin
      send_event(npq_pkg::CMD_RAISE, npq_pkg::PRIO_W'(i * 10), npq_pkg::HID_W'(i));
    end
    send_event(npq_pkg::CMD_RAISE, 8'd60, 8'h07);
    repeat (7) send_event(npq_pkg::CMD_COMPLETE, 8'd0, 8'h00);
    // busy with a lower raise, then start from queue at outermost level
    send_event(npq_pkg::CMD_RAISE,    8'd128, 8'h55);
    send_event(npq_pkg::CMD_RAISE,    8'd127, 8'h80);
    send_event(npq_pkg::CMD_COMPLETE, 8'd0,   8'h00);
    send_event(npq_pkg::CMD_COMPLETE, 8'd0,   8'h00);

    sent = 0;
    while (sent < N_RANDOM) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       raise_pct = 85;
        1:       raise_pct = 20;
        default: raise_pct = 55;
      endcase
      repeat (phase_len) begin
        cmd = ($urandom_range(0, 99) < raise_pct) ? npq_pkg::CMD_RAISE : npq_pkg::CMD_COMPLETE;
        sel = $urandom_range(0, 15);
        if (sel == 0)      prio = 8'd0;
        else if (sel == 1) prio = 8'd255;
        else if (sel == 2) prio = 8'd1;
        else if (sel < 7)  prio = npq_pkg::PRIO_W'($urandom_range(1, 4));
        else               prio = npq_pkg::PRIO_W'($urandom_range(0, 255));
        send_event(cmd, prio, npq_pkg::HID_W'($urandom_range(0, 255)));
        sent++;
      end
    end

    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
